>>> src/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values and round helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package sha256_pkg;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic       fin;
    logic [7:0] data;
  } cmd_t;

  function automatic word_t init_hash(input logic [2:0] idx);
    word_t r;
    case (idx)
      3'd0:    r = 32'h6a09e667;
      3'd1:    r = 32'hbb67ae85;
      3'd2:    r = 32'h3c6ef372;
      3'd3:    r = 32'ha54ff53a;
      3'd4:    r = 32'h510e527f;
      3'd5:    r = 32'h9b05688c;
      3'd6:    r = 32'h1f83d9ab;
      3'd7:    r = 32'h5be0cd19;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  function automatic word_t round_k(input logic [5:0] idx);
    word_t r;
    case (idx)
      6'd0: r = 32'h428a2f98; 6'd1: r = 32'h71374491; 6'd2: r = 32'hb5c0fbcf;
      6'd3: r = 32'he9b5dba5; 6'd4: r = 32'h3956c25b; 6'd5: r = 32'h59f111f1;
      6'd6: r = 32'h923f82a4; 6'd7: r = 32'hab1c5ed5; 6'd8: r = 32'hd807aa98;
      6'd9: r = 32'h12835b01; 6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
      6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
      6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
      6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
      6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
      6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
      6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
      6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
      6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
      6'd63: r = 32'hc67178f2;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  function automatic word_t ror32(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

`default_nettype wire

>>> src/sha256_byte_stream_hasher_core.sv
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Hashes a byte stream and emits the digest as eight 32-bit words.
// ----------------------------------------------------------------------------
// channel | handshake        | payload
// in      | valid_i/ready_o  | kind_i, data_byte_i
// out     | valid_o/ready_i  | digest_word_o, word_index_o, last_word_o
//
// Each byte is shifted into the block register; the 64th byte of a block starts a
// compression (one round per cycle in a single round unit).
// Finish: padding one byte per cycle, one or two compressions, 8 output beats.
// A two-entry queue keeps taking items while the engine works, until both entries are full.
// Reset loads the initial hash values and clears the counters and block register.
`default_nettype none

module sha256_byte_stream_hasher_core import sha256_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             ready_o,
  input  wire logic        kind_i,
  input  wire logic [7:0]  data_byte_i,
  output logic             valid_o,
  input  wire logic        ready_i,
  output logic [31:0]      digest_word_o,
  output logic [2:0]       word_index_o,
  output logic             last_word_o
);

  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  sha256_front u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o, .kind_i, .data_byte_i,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  sha256_engine u_engine (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready),
    .cmd_i(cmd), .valid_o, .ready_i, .digest_word_o, .word_index_o, .last_word_o
  );

  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (last_word_o == (word_index_o == 3'd7)))
    else $error("last flag mismatch");

  a_no_take_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !cmd_ready)
    else $error("engine took command while emitting");

  a_idx_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && ready_i && !last_word_o) |=> (valid_o &&
      word_index_o == $past(word_index_o) + 3'd1))
    else $error("digest index skipped");

endmodule

`default_nettype wire

>>> src/sha256_front.sv
// ----------------------------------------------------------------------------
// SHA-256 front end
// Two-entry command queue between the input port and the block engine.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_front import sha256_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic valid_i,
  output logic      ready_o,
  input  wire logic kind_i,
  input  wire logic [7:0] data_byte_i,
  output logic      cmd_valid_o,
  input  wire logic cmd_ready_i,
  output cmd_t      cmd_o
);

  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign ready_o     = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign push        = valid_i && ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{fin: kind_i, data: data_byte_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

>>> src/sha256_engine.sv
// ----------------------------------------------------------------------------
// SHA-256 block engine
// Byte buffering, padding, 64-round compression and digest output.
// Bytes shift into the 16-word schedule register, first byte ending up on top.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_engine import sha256_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cmd_valid_i,
  output logic       cmd_ready_o,
  input  cmd_t       cmd_i,
  output logic       valid_o,
  input  wire logic  ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0] word_index_o,
  output logic       last_word_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPad  = 3'd1;
  localparam logic [2:0] StRnd  = 3'd2;
  localparam logic [2:0] StAdd  = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0]  st_q;
  logic [5:0]  fill_q;
  logic [63:0] cnt_q, bits_q;
  word_t       h_q [8];
  word_t       v_q [8];
  word_t       w_q [16];
  logic [5:0]  rnd_q;
  logic        fin_q, pass2_q;
  logic [2:0]  oidx_q;

  word_t s0, s1, ch, mj, t1, t2, wcur, wnew, sg0, sg1;

  assign wcur = w_q[0];
  always_comb begin
    sg0  = ror32(w_q[1], 7) ^ ror32(w_q[1], 18) ^ (w_q[1] >> 3);
    sg1  = ror32(w_q[14], 17) ^ ror32(w_q[14], 19) ^ (w_q[14] >> 10);
    wnew = w_q[0] + sg0 + w_q[9] + sg1;
    s1   = ror32(v_q[4], 6) ^ ror32(v_q[4], 11) ^ ror32(v_q[4], 25);
    ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1   = v_q[7] + s1 + ch + round_k(rnd_q) + wcur;
    s0   = ror32(v_q[0], 2) ^ ror32(v_q[0], 13) ^ ror32(v_q[0], 22);
    mj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2   = s0 + mj;
  end

  assign cmd_ready_o   = (st_q == StIdle);
  assign valid_o       = (st_q == StOut);
  assign digest_word_o = h_q[oidx_q];
  assign word_index_o  = oidx_q;
  assign last_word_o   = (oidx_q == 3'd7);

  // Byte shifted in: append/0x80 when idle, one padding byte per cycle in StPad.
  logic [7:0] pad_byte;
  logic [7:0] shift_byte;
  logic [2:0] lsel;
  always_comb begin
    lsel = 3'd7 - fill_q[2:0];
    pad_byte = 8'h00;
    if (pass2_q && fill_q >= 6'd56) pad_byte = bits_q[{lsel, 3'b000} +: 8];
    shift_byte = (st_q == StPad) ? pad_byte : (cmd_i.fin ? 8'h80 : cmd_i.data);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      fill_q  <= '0;
      cnt_q   <= '0;
      bits_q  <= '0;
      rnd_q   <= '0;
      fin_q   <= 1'b0;
      pass2_q <= 1'b0;
      oidx_q  <= '0;
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= init_hash(3'(i));
        v_q[i] <= '0;
      end
      for (int i = 0; i < 16; i++) w_q[i] <= '0;
    end else begin
      case (st_q)
        StIdle: begin
          if (cmd_valid_i) begin
            fill_q <= fill_q + 6'd1;
            fin_q  <= cmd_i.fin;
            if (cmd_i.fin) begin
              bits_q  <= {cnt_q[60:0], 3'b000};
              // room for the length in this block?
              pass2_q <= (fill_q < 6'd56);
              if (fill_q == 6'd63) st_q <= StRnd;
              else                 st_q <= StPad;
            end else begin
              cnt_q <= cnt_q + 64'd1;
              if (fill_q == 6'd63) st_q <= StRnd;
            end
            rnd_q <= '0;
            for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
            for (int i = 0; i < 15; i++) w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
            w_q[15] <= {w_q[15][23:0], shift_byte};
          end
        end
        StPad: begin
          fill_q <= fill_q + 6'd1;
          if (fill_q == 6'd63) st_q <= StRnd;
          rnd_q <= '0;
          for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
          for (int i = 0; i < 15; i++) w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
          w_q[15] <= {w_q[15][23:0], shift_byte};
        end
        StRnd: begin
          v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
          v_q[4] <= v_q[3] + t1;
          v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
          v_q[0] <= t1 + t2;
          for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
          w_q[15] <= wnew;
          rnd_q <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) st_q <= StAdd;
        end
        StAdd: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
          if (!fin_q) begin
            st_q <= StIdle;
          end else if (!pass2_q) begin
            pass2_q <= 1'b1;
            st_q    <= StPad;
          end else begin
            oidx_q <= '0;
            st_q   <= StOut;
          end
        end
        StOut: begin
          if (ready_i) begin
            oidx_q <= oidx_q + 3'd1;
            if (oidx_q == 3'd7) begin
              st_q   <= StIdle;
              fin_q  <= 1'b0;
              cnt_q  <= '0;
              fill_q <= '0;
              for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
            end
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> test/tb_sha256_byte_stream_hasher_core.sv
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher testbench
// Feeds byte and finish beats with random bursts and output stalls. Every
// digest word is checked against an in-bench SHA-256 model.
// ----------------------------------------------------------------------------
module tb_sha256_byte_stream_hasher_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        ready_o;
  logic        kind_i = 1'b0;
  logic [7:0]  data_byte_i = 8'h00;
  logic        valid_o;
  logic        ready_i = 1'b0;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  sha256_byte_stream_hasher_core dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [31:0]  sha_state [8];
  logic [7:0]   blk [64];
  logic [63:0]  msg_len;
  logic [5:0]   blk_fill;
  digest_beat_t digest_q [$];
  int           errors = 0;

  localparam logic [31:0] SHA_IV [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
    32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic sha_compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + w[i-7]
           + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
           + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
    for (int i = 0; i < 8; i++) v[i] = sha_state[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) sha_state[i] += v[i];
  endtask

  task automatic sha_restart();
    for (int i = 0; i < 8; i++) sha_state[i] = SHA_IV[i];
    msg_len = '0;
    blk_fill = '0;
  endtask

  task automatic sha_absorb(logic kind, logic [7:0] b);
    logic [63:0] bits;
    int p;
    digest_beat_t beat;
    if (kind == KIND_BYTE) begin
      blk[blk_fill] = b;
      blk_fill++;
      msg_len++;
      if (blk_fill == 0) sha_compress();
    end else begin
      bits = msg_len << 3;
      p = blk_fill;
      blk[p] = 8'h80;
      p++;
      if (p > 56) begin
        while (p < 64) begin
          blk[p] = 8'h00;
          p++;
        end
        sha_compress();
        p = 0;
      end
      while (p < 56) begin
        blk[p] = 8'h00;
        p++;
      end
      for (int i = 0; i < 8; i++) blk[56+i] = bits[63-8*i -: 8];
      sha_compress();
      for (int i = 0; i < 8; i++) begin
        beat.word = sha_state[i];
        beat.idx  = 3'(i);
        beat.last = (i == 7);
        digest_q  = {digest_q, beat};
      end
      sha_restart();
    end
  endtask

  // Send one beat; bursts with random gaps between them
  int burst_left = 0;
  task automatic send_beat(logic kind, logic [7:0] b);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    burst_left--;
    valid_i <= 1'b1;
    kind_i <= kind;
    data_byte_i <= b;
    @(posedge clk_i);
    while (!ready_o) @(posedge clk_i);
    sha_absorb(kind, b);
    if (burst_left == 0) valid_i <= 1'b0;
  endtask

  // Receiver stall pattern: runs of ready and of stall
  initial begin
    int run;
    @(posedge rst_ni);
    forever begin
      run = $urandom_range(1, 12);
      ready_i <= ($urandom_range(0, 2) != 0);
      repeat (run) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    digest_beat_t e;
    if (rst_ni && valid_o && ready_i) begin
      if (digest_q.size() == 0) begin
        $error("digest beat with nothing expected: %h", digest_word_o);
        errors++;
      end else begin
        e = digest_q.pop_front();
        if (digest_word_o !== e.word) begin
          $error("digest_word exp %h got %h", e.word, digest_word_o); errors++;
        end
        if (word_index_o !== e.idx) begin
          $error("word_index exp %0d got %0d", e.idx, word_index_o); errors++;
        end
        if (last_word_o !== e.last) begin
          $error("last_word exp %0d got %0d", e.last, last_word_o); errors++;
        end
      end
    end
  end

  typedef struct {
    int          nbytes;
    logic [7:0]  fill;
    logic [31:0] word0;
  } msg_row_t;

  // Empty, "abc", and a length that needs a second padding block;
  // word 0 known for empty and "abc"
  msg_row_t msg_tab [] = '{
    '{0,   8'h00, 32'he3b0c442},
    '{-3,  8'h00, 32'hba7816bf},
    '{63,  8'h5a, 32'h0}
  };

  initial begin
    logic [7:0] abc [3] = '{8'h61, 8'h62, 8'h63};
    int n;
    sha_restart();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (msg_tab[r]) begin
      n = msg_tab[r].nbytes;
      if (n < 0) for (int i = 0; i < 3; i++) send_beat(KIND_BYTE, abc[i]);
      else for (int i = 0; i < n; i++) send_beat(KIND_BYTE, msg_tab[r].fill ^ 8'(i));
      send_beat(KIND_FINISH, 8'h00);
      if (msg_tab[r].word0 != 0 && digest_q[digest_q.size()-8].word !== msg_tab[r].word0) begin
        $error("digest_word exp %h got %h (model)", msg_tab[r].word0,
               digest_q[digest_q.size()-8].word);
        errors++;
      end
    end
    // Random short messages
    for (int m = 0; m < 4; m++) begin
      n = $urandom_range(0, 12);
      for (int i = 0; i < n; i++) send_beat(KIND_BYTE, 8'($urandom));
      send_beat(KIND_FINISH, 8'($urandom));
    end
    if (burst_left != 0) valid_i <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
